// ===== hdl/bqbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bqbc_pkg
// Shared types and character codes for the bracket and quote balance checker.
// ---------------------------------------------------------------------------
package bqbc_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    VD_BALANCED   = 2'd0,
    VD_MISSING    = 2'd1,
    VD_UNEXPECTED = 2'd2,
    VD_TOO_DEEP   = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2
  } quote_mode_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stack_op_t;

  // stack entry kinds
  localparam logic KIND_BRACE = 1'b0;
  localparam logic KIND_PAREN = 1'b1;

  typedef struct packed {
    logic       valid;
    verdict_t   verdict;
    logic [7:0] culprit;
  } result_t;

endpackage

// ===== hdl/bqbc_in_if.sv =====
// ---------------------------------------------------------------------------
// bqbc_in_if
// Text byte channel: valid/ready handshake with one byte per transfer.
// ---------------------------------------------------------------------------
interface bqbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== hdl/bqbc_out_if.sv =====
// ---------------------------------------------------------------------------
// bqbc_out_if
// Verdict channel: valid/ready handshake with verdict and culprit character.
// ---------------------------------------------------------------------------
interface bqbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [7:0] culprit_char;

  modport source (output valid, output verdict, output culprit_char, input ready);
  modport sink (input valid, input verdict, input culprit_char, output ready);
endinterface

// ===== hdl/bqbc_scan.sv =====
// ---------------------------------------------------------------------------
// bqbc_scan
// Scanner state: bracket stack, quote mode, escape and error flags. Steps
// once per enabled byte and presents the verdict for that byte, if any.
// ---------------------------------------------------------------------------
module bqbc_scan #(
  parameter int STACK_DEPTH = 32,
  parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        text_byte,
  output bqbc_pkg::result_t res,
  output logic [DW-1:0]     depth
);
  import bqbc_pkg::*;

  // stack_r[0] is the innermost entry
  logic [STACK_DEPTH-1:0] stack_r;
  logic [DW-1:0]          depth_r, depth_nxt;
  quote_mode_t            qm_r, qm_nxt;
  logic                   esc_r, esc_nxt;
  logic                   err_r, err_nxt;
  stack_op_t              op;
  logic                   push_kind;
  logic [7:0]             qc;
  logic                   empty, full, top;

  assign empty = (depth_r == '0);
  assign full  = (depth_r == DW'(STACK_DEPTH));
  assign top   = stack_r[0];
  assign qc    = (qm_r == QM_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
  assign depth = depth_r;

  always_comb begin
    depth_nxt   = depth_r;
    qm_nxt      = qm_r;
    esc_nxt     = esc_r;
    err_nxt     = err_r;
    op          = STK_HOLD;
    push_kind   = KIND_BRACE;
    res.valid   = 1'b0;
    res.verdict = VD_BALANCED;
    res.culprit = CH_NUL;

    priority if (err_r) begin
      if (text_byte == CH_NUL) err_nxt = 1'b0;
    end else if (qm_r != QM_NONE) begin
      priority if (text_byte == CH_NUL) begin
        res.valid   = 1'b1;
        res.verdict = VD_MISSING;
        res.culprit = qc;
        depth_nxt   = '0;
        qm_nxt      = QM_NONE;
        esc_nxt     = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (text_byte == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (text_byte == qc) begin
        qm_nxt = QM_NONE;
      end else begin
        qm_nxt = qm_r;
      end
    end else begin
      unique case (text_byte)
        CH_NUL: begin
          res.valid   = 1'b1;
          res.verdict = empty ? VD_BALANCED : VD_MISSING;
          res.culprit = empty ? CH_NUL : (top ? CH_RPAREN : CH_RBRACE);
          depth_nxt   = '0;
        end
        CH_LBRACE, CH_LPAREN: begin
          if (text_byte == CH_LBRACE && !empty && top == KIND_PAREN) begin
            res.valid   = 1'b1;
            res.verdict = VD_UNEXPECTED;
            res.culprit = text_byte;
          end else if (full) begin
            res.valid   = 1'b1;
            res.verdict = VD_TOO_DEEP;
            res.culprit = CH_NUL;
          end else begin
            op        = STK_PUSH;
            push_kind = (text_byte == CH_LPAREN) ? KIND_PAREN : KIND_BRACE;
            depth_nxt = depth_r + DW'(1);
          end
        end
        CH_DQUOTE: qm_nxt = QM_DOUBLE;
        CH_SQUOTE: qm_nxt = QM_SINGLE;
        CH_RBRACE, CH_RPAREN: begin
          if (!empty && top == (text_byte == CH_RPAREN)) begin
            op        = STK_POP;
            depth_nxt = depth_r - DW'(1);
          end else begin
            res.valid   = 1'b1;
            res.verdict = VD_UNEXPECTED;
            res.culprit = text_byte;
          end
        end
        CH_HASH: begin
          res.valid   = 1'b1;
          res.verdict = VD_UNEXPECTED;
          res.culprit = text_byte;
        end
        default: ;
      endcase
      if (res.valid && res.verdict != VD_BALANCED && res.verdict != VD_MISSING) begin
        err_nxt   = 1'b1;
        depth_nxt = '0;
        qm_nxt    = QM_NONE;
        esc_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      qm_r    <= QM_NONE;
      esc_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (en) begin
      depth_r <= depth_nxt;
      qm_r    <= qm_nxt;
      esc_r   <= esc_nxt;
      err_r   <= err_nxt;
    end
  end

  generate
    if (STACK_DEPTH == 1) begin : g_stk1
      always_ff @(posedge clk) begin
        if (en && op == STK_PUSH) stack_r <= push_kind;
      end
    end else begin : g_stkn
      always_ff @(posedge clk) begin
        if (en) begin
          unique case (op)
            STK_PUSH: stack_r <= {stack_r[STACK_DEPTH-2:0], push_kind};
            STK_POP:  stack_r <= {stack_r[STACK_DEPTH-1], stack_r[STACK_DEPTH-1:1]};
            default:  stack_r <= stack_r;
          endcase
        end
      end
    end
  endgenerate

endmodule

// ===== hdl/bracket_quote_balance_checker_top.sv =====
// ---------------------------------------------------------------------------
// bracket_quote_balance_checker_top
// Checks brace, parenthesis and quote balance of a byte stream of C text.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one text byte per transfer; a zero byte ends the text.
//   out_ch : at most one verdict per text, with culprit character. A verdict
//            comes at the terminator or at the first error; after an error
//            the rest of the text up to its terminator gives no transfer.
//   Path:    a transferred byte waits in the input register; as it is scanned
//            its verdict, if any, is registered and driven onto out_ch.
//   Throughput: one byte per cycle unless stalled. The scan is a single stage
//            with the bracket stack as a shift register, only its top bit read.
//   Stall: a held verdict blocks scanning of the byte behind it; in_ch.ready
//            drops once that input register is full as well.
//   Reset: rst_n (synchronous) empties the pipeline and clears depth, quote
//            mode, escape and error flags; stack contents are left as is.
//   STACK_DEPTH sets the nesting limit (1..256); one more opener gives the
//            too-deep verdict.
// ---------------------------------------------------------------------------
module bracket_quote_balance_checker_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bqbc_in_if.sink    in_ch,
  bqbc_out_if.source out_ch
);
  import bqbc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          out_valid_r;
  result_t       out_res_r;
  result_t       scan_res;
  logic [DW-1:0] depth;
  logic          advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_byte_r <= in_ch.text_byte;
  end

  bqbc_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .text_byte (s1_byte_r),
    .res       (scan_res),
    .depth     (depth)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && scan_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_res.valid) out_res_r <= scan_res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_res_r.verdict;
  assign out_ch.culprit_char = out_res_r.culprit;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth <= DW'(STACK_DEPTH))
    else $error("nesting depth beyond stack size");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && scan_res.valid |=> depth == '0)
    else $error("depth not cleared after verdict");

  a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("verdict without a scanned byte");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free stage");

endmodule
